// ===== sv/huff_pkg.sv =====
// shared types, codes and sizes for the huffman build, encode and decode block
package huff_pkg;

	localparam int ALPHA   = 128;
	localparam int SYM_W   = 7;
	localparam int NODE_W  = 8;
	localparam int NPOOL   = 255;
	localparam int MAXLEN  = 32;
	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int CNT_W   = 16;
	localparam int WT_W    = 24;
	localparam int HEAP_D  = ALPHA + 1;
	localparam int STK_D   = 256;
	localparam int DIST_W  = 8;
	localparam int OP_W    = 6;

	localparam logic [2:0] CMD_COUNT  = 3'd0;
	localparam logic [2:0] CMD_BUILD  = 3'd1;
	localparam logic [2:0] CMD_ENCODE = 3'd2;
	localparam logic [2:0] CMD_DECODE = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_UNKNOWN    = 3'd1;
	localparam logic [2:0] ST_FEW        = 3'd2;
	localparam logic [2:0] ST_INCOMPLETE = 3'd3;
	localparam logic [2:0] ST_TOO_LONG   = 3'd4;
	localparam logic [2:0] ST_NOT_BUILT  = 3'd5;

	localparam logic [OP_W-1:0] OP_IDLE     = 6'd0;
	localparam logic [OP_W-1:0] OP_DISP     = 6'd1;
	localparam logic [OP_W-1:0] OP_CLR      = 6'd2;
	localparam logic [OP_W-1:0] OP_CNT_RD   = 6'd3;
	localparam logic [OP_W-1:0] OP_CNT_WR   = 6'd4;
	localparam logic [OP_W-1:0] OP_SCAN_RD  = 6'd5;
	localparam logic [OP_W-1:0] OP_SCAN_CHK = 6'd6;
	localparam logic [OP_W-1:0] OP_SCAN_END = 6'd7;
	localparam logic [OP_W-1:0] OP_LEAF_RD  = 6'd8;
	localparam logic [OP_W-1:0] OP_LEAF_CHK = 6'd9;
	localparam logic [OP_W-1:0] OP_PSH_INIT = 6'd10;
	localparam logic [OP_W-1:0] OP_PSH_CHK  = 6'd11;
	localparam logic [OP_W-1:0] OP_PSH_WRD  = 6'd12;
	localparam logic [OP_W-1:0] OP_PSH_CMP  = 6'd13;
	localparam logic [OP_W-1:0] OP_PSH_FIN  = 6'd14;
	localparam logic [OP_W-1:0] OP_POP_TOP  = 6'd15;
	localparam logic [OP_W-1:0] OP_POP_TOPD = 6'd16;
	localparam logic [OP_W-1:0] OP_POP_CHK  = 6'd17;
	localparam logic [OP_W-1:0] OP_POP_L    = 6'd18;
	localparam logic [OP_W-1:0] OP_POP_L2   = 6'd19;
	localparam logic [OP_W-1:0] OP_POP_R    = 6'd20;
	localparam logic [OP_W-1:0] OP_POP_LAST = 6'd21;
	localparam logic [OP_W-1:0] OP_MRG_WA   = 6'd22;
	localparam logic [OP_W-1:0] OP_MRG_WB   = 6'd23;
	localparam logic [OP_W-1:0] OP_MRG_NEW  = 6'd24;
	localparam logic [OP_W-1:0] OP_WLK_INIT = 6'd25;
	localparam logic [OP_W-1:0] OP_WLK_POP  = 6'd26;
	localparam logic [OP_W-1:0] OP_WLK_RD   = 6'd27;
	localparam logic [OP_W-1:0] OP_WLK_CHK  = 6'd28;
	localparam logic [OP_W-1:0] OP_WLK_PSHL = 6'd29;
	localparam logic [OP_W-1:0] OP_ENC_RD   = 6'd30;
	localparam logic [OP_W-1:0] OP_ENC      = 6'd31;
	localparam logic [OP_W-1:0] OP_DEC_RD   = 6'd32;
	localparam logic [OP_W-1:0] OP_DEC_CH   = 6'd33;
	localparam logic [OP_W-1:0] OP_DEC      = 6'd34;
	localparam logic [OP_W-1:0] OP_OUT      = 6'd35;

	typedef struct packed {
		logic [2:0]       command;
		logic [SYM_W-1:0] symbol;
		logic             bit_req;
		logic             last;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [SYM_W-1:0]  symbol_out;
		logic              symbol_valid;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
		logic [DIST_W-1:0] distinct_symbols;
	} rsp_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} stk_ent_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            second;
	} huff_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       built;
		logic       last_sym;
		logic       cnt_nz;
		logic       few;
		logic       hs_gt1;
		logic       j_zero;
		logic       w_le;
		logic       l_ge;
		logic       r_in;
		logic       sp_zero;
		logic       is_leaf;
		logic       too_long;
		logic       out_free;
	} huff_stat_t;

endpackage

// ===== sv/huff_ctrl.sv =====
// sequencer that steps the datapath through count, build, encode, decode and clear
module huff_ctrl
	import huff_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  huff_stat_t st,
	output huff_cmd_t  ctl
);

	logic [OP_W-1:0] state_q, state_nxt;
	logic            second_q;
	logic            clr_cmd_q;
	logic            merge_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			OP_IDLE:     if (req_valid) state_nxt = OP_DISP;
			OP_DISP: begin
				unique case (st.cmd)
					CMD_COUNT:  state_nxt = OP_CNT_RD;
					CMD_BUILD:  state_nxt = OP_SCAN_RD;
					CMD_ENCODE: state_nxt = st.built ? OP_ENC_RD : OP_OUT;
					CMD_DECODE: state_nxt = st.built ? OP_DEC_RD : OP_OUT;
					CMD_CLEAR:  state_nxt = OP_CLR;
					default:    state_nxt = OP_OUT;
				endcase
			end
			OP_CLR:      if (st.last_sym) state_nxt = clr_cmd_q ? OP_OUT : OP_IDLE;
			OP_CNT_RD:   state_nxt = OP_CNT_WR;
			OP_CNT_WR:   state_nxt = OP_OUT;
			OP_SCAN_RD:  state_nxt = OP_SCAN_CHK;
			OP_SCAN_CHK: state_nxt = st.last_sym ? OP_SCAN_END : OP_SCAN_RD;
			OP_SCAN_END: state_nxt = st.few ? OP_OUT : OP_LEAF_RD;
			OP_LEAF_RD:  state_nxt = OP_LEAF_CHK;
			OP_LEAF_CHK: begin
				if (st.cnt_nz) state_nxt = OP_PSH_INIT;
				else state_nxt = st.last_sym ? OP_POP_TOP : OP_LEAF_RD;
			end
			OP_PSH_INIT: state_nxt = OP_PSH_CHK;
			OP_PSH_CHK:  state_nxt = st.j_zero ? OP_PSH_FIN : OP_PSH_WRD;
			OP_PSH_WRD:  state_nxt = OP_PSH_CMP;
			OP_PSH_CMP:  state_nxt = st.w_le ? OP_PSH_FIN : OP_PSH_CHK;
			OP_PSH_FIN: begin
				if (merge_q) state_nxt = st.hs_gt1 ? OP_POP_TOP : OP_WLK_INIT;
				else state_nxt = st.last_sym ? OP_POP_TOP : OP_LEAF_RD;
			end
			OP_POP_TOP:  state_nxt = OP_POP_TOPD;
			OP_POP_TOPD: state_nxt = OP_POP_CHK;
			OP_POP_CHK:  state_nxt = st.l_ge ? OP_POP_LAST : OP_POP_L;
			OP_POP_L:    state_nxt = OP_POP_L2;
			OP_POP_L2:   state_nxt = st.r_in ? OP_POP_R : OP_POP_CHK;
			OP_POP_R:    state_nxt = OP_POP_CHK;
			OP_POP_LAST: state_nxt = second_q ? OP_MRG_WA : OP_POP_TOP;
			OP_MRG_WA:   state_nxt = OP_MRG_WB;
			OP_MRG_WB:   state_nxt = OP_MRG_NEW;
			OP_MRG_NEW:  state_nxt = OP_PSH_INIT;
			OP_WLK_INIT: state_nxt = OP_WLK_POP;
			OP_WLK_POP:  state_nxt = st.sp_zero ? OP_OUT : OP_WLK_RD;
			OP_WLK_RD:   state_nxt = OP_WLK_CHK;
			OP_WLK_CHK: begin
				if (st.is_leaf) state_nxt = OP_WLK_POP;
				else state_nxt = st.too_long ? OP_OUT : OP_WLK_PSHL;
			end
			OP_WLK_PSHL: state_nxt = OP_WLK_POP;
			OP_ENC_RD:   state_nxt = OP_ENC;
			OP_ENC:      state_nxt = OP_OUT;
			OP_DEC_RD:   state_nxt = OP_DEC_CH;
			OP_DEC_CH:   state_nxt = OP_DEC;
			OP_DEC:      state_nxt = OP_OUT;
			OP_OUT:      if (st.out_free) state_nxt = OP_IDLE;
			default:     state_nxt = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= OP_CLR;
			second_q  <= 1'b0;
			clr_cmd_q <= 1'b0;
			merge_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == OP_IDLE) clr_cmd_q <= 1'b0;
			if (state_q == OP_DISP && st.cmd == CMD_CLEAR) clr_cmd_q <= 1'b1;
			if (state_q == OP_SCAN_END) merge_q <= 1'b0;
			if (state_q == OP_MRG_NEW) merge_q <= 1'b1;
			if (state_q == OP_POP_LAST) second_q <= !second_q;
		end
	end

	assign ctl.op     = state_q;
	assign ctl.second = second_q;

endmodule

// ===== sv/huff_dp.sv =====
// datapath: counters, node pool, heap, walk stack, code table and result register
module huff_dp
	import huff_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  huff_cmd_t  ctl,
	input  logic       req_valid,
	input  req_t       req,
	input  logic       rsp_stall,
	output logic       rsp_valid,
	output rsp_t       rsp,
	output huff_stat_t st
);

	logic [CNT_W-1:0]  cnt_mem [ALPHA];
	logic [WT_W-1:0]   wt_mem  [NPOOL];
	logic [7:0]        lf_mem  [NPOOL];
	logic [NODE_W-1:0] lc_mem  [NPOOL];
	logic [NODE_W-1:0] rc_mem  [NPOOL];
	logic [NODE_W-1:0] hp_mem  [HEAP_D];
	stk_ent_t          stk_mem [STK_D];
	logic [CODE_W-1:0] cb_mem  [ALPHA];
	logic [LEN_W-1:0]  cl_mem  [ALPHA];

	logic [CNT_W-1:0]  cnt_rd_q;
	logic [WT_W-1:0]   wt_rd_q;
	logic [7:0]        lf_rd_q;
	logic [NODE_W-1:0] lc_rd_q, rc_rd_q, hp_rd_q;
	stk_ent_t          stk_rd_q;
	logic [CODE_W-1:0] cb_rd_q;
	logic [LEN_W-1:0]  cl_rd_q;

	logic              cnt_re, cnt_we, wt_re, wt_we, lf_re, lf_we, lc_re, lc_we, rc_we;
	logic              hp_re, hp_we, stk_re, stk_we, cb_re, cb_we, cl_we;
	logic [SYM_W-1:0]  cnt_ra, cnt_wa, cb_ra, cb_wa;
	logic [CNT_W-1:0]  cnt_wd;
	logic [NODE_W-1:0] wt_ra, wt_wa, nd_ra, nd_wa, hp_ra, hp_wa, stk_ra, stk_wa;
	logic [WT_W-1:0]   wt_wd;
	logic [7:0]        lf_wd;
	logic [NODE_W-1:0] lc_wd, rc_wd, hp_wd;
	stk_ent_t          stk_wd;
	logic [CODE_W-1:0] cb_wd;
	logic [LEN_W-1:0]  cl_wd;

	req_t              req_q;
	logic [7:0]        s_q, dcnt_q, hs_q, nu_q, i_q, qend_q, sp_q;
	logic [DIST_W-1:0] dist_q;
	logic [NODE_W-1:0] nd_q, idx_q, a_q, b_q, hl_q, hr_q, root_q, dnode_q, c_q;
	logic [WT_W-1:0]   w_q, wa_q, wl_q;
	stk_ent_t          e_q;
	logic              built_q;
	logic [2:0]        res_status_q;
	logic [SYM_W-1:0]  res_sym_q;
	logic              res_vld_q;
	logic [CODE_W-1:0] res_bits_q;
	logic [LEN_W-1:0]  res_len_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [8:0]        l9, l1;
	logic              r_less, out_free;
	logic [NODE_W-1:0] child;
	logic [NODE_W-1:0] dec_cur;
	logic              dec_vld;
	logic [2:0]        dec_status;

	assign l9       = {i_q, 1'b0};
	assign l1       = l9 + 9'd1;
	assign r_less   = wt_rd_q < wl_q;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign child    = req_q.bit_req ? rc_rd_q : lc_rd_q;

	assign st.cmd      = req_q.command;
	assign st.built    = built_q;
	assign st.last_sym = s_q == 8'(ALPHA - 1);
	assign st.cnt_nz   = cnt_rd_q != '0;
	assign st.few      = dcnt_q < 8'd2;
	assign st.hs_gt1   = hs_q > 8'd1;
	assign st.j_zero   = i_q[7:1] == '0;
	assign st.w_le     = wt_rd_q <= w_q;
	assign st.l_ge     = l9 >= {1'b0, qend_q};
	assign st.r_in     = l1 < {1'b0, qend_q};
	assign st.sp_zero  = sp_q == '0;
	assign st.is_leaf  = lf_rd_q[7];
	assign st.too_long = e_q.len >= LEN_W'(MAXLEN) || sp_q >= 8'(NPOOL - 1);
	assign st.out_free = out_free;

	always_comb begin
		dec_cur    = c_q;
		dec_vld    = 1'b0;
		dec_status = ST_OK;
		if (lf_rd_q[7]) begin
			dec_vld = 1'b1;
			dec_cur = root_q;
		end
		if (req_q.last && dec_cur != root_q) begin
			dec_status = ST_INCOMPLETE;
			dec_cur    = root_q;
		end
	end

	always_comb begin
		cnt_re = 1'b0; cnt_we = 1'b0; cnt_ra = '0; cnt_wa = '0; cnt_wd = '0;
		wt_re = 1'b0; wt_we = 1'b0; wt_ra = '0; wt_wa = '0; wt_wd = '0;
		lf_re = 1'b0; lf_we = 1'b0; lc_re = 1'b0; lc_we = 1'b0; rc_we = 1'b0;
		nd_ra = '0; nd_wa = '0; lf_wd = '0; lc_wd = '0; rc_wd = '0;
		hp_re = 1'b0; hp_we = 1'b0; hp_ra = '0; hp_wa = '0; hp_wd = '0;
		stk_re = 1'b0; stk_we = 1'b0; stk_ra = '0; stk_wa = '0; stk_wd = '0;
		cb_re = 1'b0; cb_we = 1'b0; cl_we = 1'b0; cb_ra = '0; cb_wa = '0;
		cb_wd = '0; cl_wd = '0;
		unique case (ctl.op)
			OP_CLR: begin
				cnt_we = 1'b1;
				cnt_wa = s_q[SYM_W-1:0];
			end
			OP_CNT_RD: begin
				cnt_re = 1'b1;
				cnt_ra = req_q.symbol;
			end
			OP_CNT_WR: begin
				cnt_we = cnt_rd_q != {CNT_W{1'b1}};
				cnt_wa = req_q.symbol;
				cnt_wd = cnt_rd_q + 1'b1;
			end
			OP_SCAN_RD: begin
				cnt_re = 1'b1;
				cnt_ra = s_q[SYM_W-1:0];
				cl_we  = 1'b1;
				cb_wa  = s_q[SYM_W-1:0];
			end
			OP_LEAF_RD: begin
				cnt_re = 1'b1;
				cnt_ra = s_q[SYM_W-1:0];
			end
			OP_LEAF_CHK: begin
				wt_we = st.cnt_nz;
				wt_wa = nu_q;
				wt_wd = {{(WT_W - CNT_W){1'b0}}, cnt_rd_q};
				lf_we = st.cnt_nz;
				nd_wa = nu_q;
				lf_wd = {1'b1, s_q[SYM_W-1:0]};
			end
			OP_PSH_CHK: begin
				hp_re = !st.j_zero;
				hp_ra = {1'b0, i_q[7:1]};
			end
			OP_PSH_WRD: begin
				wt_re = 1'b1;
				wt_ra = hp_rd_q;
			end
			OP_PSH_CMP: begin
				hp_we = !st.w_le;
				hp_wa = i_q;
				hp_wd = idx_q;
			end
			OP_PSH_FIN: begin
				hp_we = 1'b1;
				hp_wa = i_q;
				hp_wd = nd_q;
			end
			OP_POP_TOP: begin
				hp_re = 1'b1;
				hp_ra = 8'd1;
			end
			OP_POP_CHK: begin
				hp_re = 1'b1;
				hp_ra = st.l_ge ? qend_q : l9[7:0];
			end
			OP_POP_L: begin
				wt_re = 1'b1;
				wt_ra = hp_rd_q;
				hp_re = 1'b1;
				hp_ra = l1[7:0];
			end
			OP_POP_L2: begin
				wt_re = st.r_in;
				wt_ra = hp_rd_q;
				hp_we = !st.r_in;
				hp_wa = i_q;
				hp_wd = hl_q;
			end
			OP_POP_R: begin
				hp_we = 1'b1;
				hp_wa = i_q;
				hp_wd = r_less ? hr_q : hl_q;
			end
			OP_POP_LAST: begin
				hp_we = 1'b1;
				hp_wa = i_q;
				hp_wd = hp_rd_q;
			end
			OP_MRG_WA: begin
				wt_re = 1'b1;
				wt_ra = a_q;
			end
			OP_MRG_WB: begin
				wt_re = 1'b1;
				wt_ra = b_q;
			end
			OP_MRG_NEW: begin
				wt_we = 1'b1;
				wt_wa = nu_q;
				wt_wd = wa_q + wt_rd_q;
				lf_we = 1'b1;
				lc_we = 1'b1;
				rc_we = 1'b1;
				nd_wa = nu_q;
				lc_wd = a_q;
				rc_wd = b_q;
			end
			OP_WLK_INIT: begin
				stk_we = 1'b1;
				stk_wd.node = nu_q - 8'd1;
			end
			OP_WLK_POP: begin
				stk_re = !st.sp_zero;
				stk_ra = sp_q - 8'd1;
			end
			OP_WLK_RD: begin
				lf_re = 1'b1;
				lc_re = 1'b1;
				nd_ra = stk_rd_q.node;
			end
			OP_WLK_CHK: begin
				cb_we  = st.is_leaf;
				cl_we  = st.is_leaf;
				cb_wa  = lf_rd_q[SYM_W-1:0];
				cb_wd  = e_q.bits;
				cl_wd  = e_q.len;
				stk_we = !st.is_leaf && !st.too_long;
				stk_wa = sp_q;
				stk_wd = '{node: rc_rd_q, bits: {e_q.bits[CODE_W-2:0], 1'b1},
					len: e_q.len + 1'b1};
			end
			OP_WLK_PSHL: begin
				stk_we = 1'b1;
				stk_wa = sp_q;
				stk_wd = '{node: lc_rd_q, bits: {e_q.bits[CODE_W-2:0], 1'b0},
					len: e_q.len + 1'b1};
			end
			OP_ENC_RD: begin
				cb_re = 1'b1;
				cb_ra = req_q.symbol;
			end
			OP_DEC_RD: begin
				lc_re = 1'b1;
				nd_ra = dnode_q;
			end
			OP_DEC_CH: begin
				lf_re = 1'b1;
				nd_ra = child;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (cnt_re) cnt_rd_q <= cnt_mem[cnt_ra];
	end

	always_ff @(posedge clk) begin
		if (wt_we) wt_mem[wt_wa] <= wt_wd;
		if (wt_re) wt_rd_q <= wt_mem[wt_ra];
	end

	always_ff @(posedge clk) begin
		if (lf_we) lf_mem[nd_wa] <= lf_wd;
		if (lf_re) lf_rd_q <= lf_mem[nd_ra];
	end

	always_ff @(posedge clk) begin
		if (lc_we) lc_mem[nd_wa] <= lc_wd;
		if (lc_re) lc_rd_q <= lc_mem[nd_ra];
	end

	always_ff @(posedge clk) begin
		if (rc_we) rc_mem[nd_wa] <= rc_wd;
		if (lc_re) rc_rd_q <= rc_mem[nd_ra];
	end

	always_ff @(posedge clk) begin
		if (hp_we) hp_mem[hp_wa] <= hp_wd;
		if (hp_re) hp_rd_q <= hp_mem[hp_ra];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (stk_re) stk_rd_q <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk) begin
		if (cb_we) cb_mem[cb_wa] <= cb_wd;
		if (cb_re) cb_rd_q <= cb_mem[cb_ra];
	end

	always_ff @(posedge clk) begin
		if (cl_we) cl_mem[cb_wa] <= cl_wd;
		if (cb_re) cl_rd_q <= cl_mem[cb_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q     <= '0;
			dcnt_q  <= '0;
			hs_q    <= '0;
			nu_q    <= '0;
			sp_q    <= '0;
			dist_q  <= '0;
			dnode_q <= '0;
			root_q  <= '0;
			built_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				OP_IDLE: if (req_valid) req_q <= req;
				OP_DISP: begin
					res_status_q <= ST_OK;
					res_sym_q    <= '0;
					res_vld_q    <= 1'b0;
					res_bits_q   <= '0;
					res_len_q    <= '0;
					s_q          <= '0;
					unique case (req_q.command) inside
						CMD_BUILD: begin
							built_q <= 1'b0;
							hs_q    <= '0;
							nu_q    <= '0;
							dcnt_q  <= '0;
							dnode_q <= '0;
						end
						CMD_CLEAR: begin
							built_q <= 1'b0;
							dist_q  <= '0;
							dnode_q <= '0;
						end
						CMD_ENCODE, CMD_DECODE: if (!built_q) res_status_q <= ST_NOT_BUILT;
						default: begin
						end
					endcase
				end
				OP_CLR:      s_q <= s_q + 8'd1;
				OP_SCAN_CHK: begin
					if (st.cnt_nz) dcnt_q <= dcnt_q + 8'd1;
					s_q <= s_q + 8'd1;
				end
				OP_SCAN_END: begin
					dist_q <= dcnt_q;
					s_q    <= '0;
					if (st.few) res_status_q <= ST_FEW;
				end
				OP_LEAF_CHK: begin
					if (st.cnt_nz) begin
						nd_q <= nu_q;
						w_q  <= {{(WT_W - CNT_W){1'b0}}, cnt_rd_q};
					end else begin
						s_q <= s_q + 8'd1;
					end
				end
				OP_PSH_INIT: begin
					i_q  <= hs_q + 8'd1;
					hs_q <= hs_q + 8'd1;
				end
				OP_PSH_WRD:  idx_q <= hp_rd_q;
				OP_PSH_CMP:  if (!st.w_le) i_q <= {1'b0, i_q[7:1]};
				OP_PSH_FIN: begin
					nu_q <= nu_q + 8'd1;
					s_q  <= s_q + 8'd1;
				end
				OP_POP_TOPD: begin
					if (ctl.second) b_q <= hp_rd_q;
					else a_q <= hp_rd_q;
					qend_q <= hs_q;
					hs_q   <= hs_q - 8'd1;
					i_q    <= 8'd1;
				end
				OP_POP_L:    hl_q <= hp_rd_q;
				OP_POP_L2: begin
					wl_q <= wt_rd_q;
					hr_q <= hp_rd_q;
					if (!st.r_in) i_q <= l9[7:0];
				end
				OP_POP_R:    i_q <= r_less ? l1[7:0] : l9[7:0];
				OP_MRG_WB:   wa_q <= wt_rd_q;
				OP_MRG_NEW: begin
					nd_q <= nu_q;
					w_q  <= wa_q + wt_rd_q;
				end
				OP_WLK_INIT: begin
					sp_q   <= 8'd1;
					root_q <= nu_q - 8'd1;
				end
				OP_WLK_POP: begin
					if (st.sp_zero) begin
						built_q <= 1'b1;
						dnode_q <= root_q;
					end else begin
						sp_q <= sp_q - 8'd1;
					end
				end
				OP_WLK_RD:   e_q <= stk_rd_q;
				OP_WLK_CHK: begin
					if (!st.is_leaf) begin
						if (st.too_long) res_status_q <= ST_TOO_LONG;
						else sp_q <= sp_q + 8'd1;
					end
				end
				OP_WLK_PSHL: sp_q <= sp_q + 8'd1;
				OP_ENC: begin
					if (cl_rd_q == '0) begin
						res_status_q <= ST_UNKNOWN;
					end else begin
						res_bits_q <= cb_rd_q;
						res_len_q  <= cl_rd_q;
					end
				end
				OP_DEC_CH:   c_q <= child;
				OP_DEC: begin
					res_status_q <= dec_status;
					res_vld_q    <= dec_vld;
					if (dec_vld) res_sym_q <= lf_rd_q[SYM_W-1:0];
					dnode_q <= dec_cur;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.op == OP_OUT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_OUT && out_free) begin
			rsp_q <= '{status: res_status_q, symbol_out: res_sym_q,
				symbol_valid: res_vld_q, code_bits: res_bits_q,
				code_length: res_len_q, distinct_symbols: dist_q};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sv/huffman_build_encode_decode_top.sv =====
// top level of the huffman build, encode and decode block
// One request at a time. Clear empties the counters at one counter per cycle;
// any request also needs its result register free. Build scans the 128
// counters and, unless fewer than two are nonzero, scans them again as the
// leaves go into the heap, then runs the heap inserts and removals and the code
// walk through single-port node, heap and stack memories. After reset the
// counter memory is cleared, during which requests are stalled. A result can
// wait on a stalled output while the next request is taken.
module huffman_build_encode_decode_top
	import huff_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	huff_cmd_t  ctl;
	huff_stat_t st;

	huff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.st        (st),
		.ctl       (ctl)
	);

	huff_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.req_valid (req_valid),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.st        (st)
	);

	assign req_stall = ctl.op != OP_IDLE;

endmodule

// ===== test/huffman_build_encode_decode_top_test.sv =====
// self-checking testbench for the huffman build, encode and decode block
module huffman_build_encode_decode_top_test;
	import huff_pkg::*;

	localparam logic [2:0] CMD_SPARE_A = 3'd5;
	localparam logic [2:0] CMD_SPARE_B = 3'd6;
	localparam logic [2:0] CMD_SPARE_C = 3'd7;
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 1800;

	typedef struct {
		logic [2:0]       cmd;
		logic [SYM_W-1:0] sym;
		logic             b;
		logic             lst;
		bit               fixed;
		logic [2:0]       st;
		logic [DIST_W-1:0] dcount;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	huffman_build_encode_decode_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	int unsigned sym_cnt[ALPHA];
	logic [WT_W-1:0] nd_wt[NPOOL];
	int nd_l[NPOOL], nd_r[NPOOL], nd_sym[NPOOL];
	bit nd_leaf[NPOOL];
	int heap[HEAP_D];
	int heap_n, pool_n, dec_at, dist_last;
	bit tree_ok;
	logic [CODE_W-1:0] tab_bits[ALPHA];
	int tab_len[ALPHA];
	int wk_nd[NPOOL], wk_len[NPOOL];
	logic [CODE_W-1:0] wk_bits[NPOOL];

	rsp_t pending[$];
	int errors = 0, cycles = 0, sent = 0, got = 0, builds_ok = 0, decoded = 0;
	bit quiet = 0, hold_req = 0;
	int stall_left = 0;

	function automatic void heap_insert(int nd);
		int i, j;
		i = heap_n + 1;
		heap_n++;
		j = i / 2;
		while (j != 0) begin
			if (nd_wt[heap[j]] <= nd_wt[nd]) break;
			heap[i] = heap[j];
			i = j;
			j = i / 2;
		end
		heap[i] = nd;
	endfunction

	function automatic int heap_take();
		int top, i, l, qend;
		top = heap[1];
		i = 1;
		heap_n--;
		qend = heap_n + 1;
		l = i * 2;
		while (l < qend) begin
			if (l + 1 < qend && nd_wt[heap[l+1]] < nd_wt[heap[l]]) l++;
			heap[i] = heap[l];
			i = l;
			l = i * 2;
		end
		heap[i] = heap[qend];
		return top;
	endfunction

	function automatic void tree_drop();
		tree_ok = 0;
		heap_n = 0;
		pool_n = 0;
		dec_at = 0;
		foreach (tab_len[s]) tab_len[s] = 0;
	endfunction

	function automatic void model_clear();
		foreach (sym_cnt[s]) sym_cnt[s] = 0;
		dist_last = 0;
		tree_drop();
	endfunction

	function automatic logic [2:0] tree_build();
		int n, sp, a, b, nd, len;
		logic [CODE_W-1:0] bits;
		n = 0;
		tree_drop();
		foreach (sym_cnt[s]) if (sym_cnt[s] != 0) n++;
		dist_last = n;
		if (n < 2) return ST_FEW;
		if (2 * n - 1 > NPOOL) return ST_TOO_LONG;
		for (int s = 0; s < ALPHA; s++) begin
			if (sym_cnt[s] == 0) continue;
			nd_wt[pool_n] = WT_W'(sym_cnt[s]);
			nd_leaf[pool_n] = 1;
			nd_sym[pool_n] = s;
			nd_l[pool_n] = 0;
			nd_r[pool_n] = 0;
			heap_insert(pool_n);
			pool_n++;
		end
		while (heap_n > 1) begin
			a = heap_take();
			b = heap_take();
			nd_wt[pool_n] = nd_wt[a] + nd_wt[b];
			nd_leaf[pool_n] = 0;
			nd_sym[pool_n] = 0;
			nd_l[pool_n] = a;
			nd_r[pool_n] = b;
			heap_insert(pool_n);
			pool_n++;
		end
		sp = 1;
		wk_nd[0] = pool_n - 1;
		wk_bits[0] = '0;
		wk_len[0] = 0;
		while (sp > 0) begin
			sp--;
			nd = wk_nd[sp];
			bits = wk_bits[sp];
			len = wk_len[sp];
			if (nd_leaf[nd]) begin
				tab_bits[nd_sym[nd]] = bits;
				tab_len[nd_sym[nd]] = len;
				continue;
			end
			if (len + 1 > MAXLEN || sp + 2 > NPOOL) begin
				tree_drop();
				return ST_TOO_LONG;
			end
			wk_nd[sp] = nd_r[nd];
			wk_bits[sp] = {bits[CODE_W-2:0], 1'b1};
			wk_len[sp] = len + 1;
			sp++;
			wk_nd[sp] = nd_l[nd];
			wk_bits[sp] = {bits[CODE_W-2:0], 1'b0};
			wk_len[sp] = len + 1;
			sp++;
		end
		dec_at = pool_n - 1;
		tree_ok = 1;
		return ST_OK;
	endfunction

	function automatic rsp_t huff_predict(req_t r);
		rsp_t o;
		int cur, root;
		o = '0;
		case (r.command)
			CMD_COUNT: if (sym_cnt[r.symbol] < CNT_MAX) sym_cnt[r.symbol]++;
			CMD_BUILD: o.status = tree_build();
			CMD_ENCODE: begin
				if (!tree_ok) o.status = ST_NOT_BUILT;
				else if (tab_len[r.symbol] == 0) o.status = ST_UNKNOWN;
				else begin
					o.code_bits = tab_bits[r.symbol];
					o.code_length = LEN_W'(tab_len[r.symbol]);
				end
			end
			CMD_DECODE: begin
				if (!tree_ok) o.status = ST_NOT_BUILT;
				else begin
					root = pool_n - 1;
					cur = dec_at < NPOOL ? dec_at : root;
					if (nd_leaf[cur]) cur = root;
					cur = r.bit_req ? nd_r[cur] : nd_l[cur];
					if (cur >= NPOOL) cur = root;
					if (nd_leaf[cur]) begin
						o.symbol_out = SYM_W'(nd_sym[cur]);
						o.symbol_valid = 1'b1;
						cur = root;
					end
					if (r.last && cur != root) begin
						o.status = ST_INCOMPLETE;
						cur = root;
					end
					dec_at = cur;
				end
			end
			CMD_CLEAR: model_clear();
			default: ;
		endcase
		o.distinct_symbols = DIST_W'(dist_last);
		return o;
	endfunction

	task automatic send(req_t r, bit fixed = 0, rsp_t typed = '0);
		rsp_t e;
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		e = huff_predict(r);
		pending.push_back(fixed ? typed : e);
		sent++;
	endtask

	task automatic send_op(logic [2:0] c, int s = 0, bit b = 0, bit l = 0);
		req_t r;
		r.command = c;
		r.symbol = SYM_W'(s);
		r.bit_req = b;
		r.last = l;
		send(r);
	endtask

	// decodes a stream of coded symbols, last set on the final bit
	task automatic decode_stream(int nsym);
		int coded[$];
		int s;
		foreach (tab_len[k]) if (tab_len[k] != 0) coded.push_back(k);
		if (coded.size() == 0) return;
		for (int n = 0; n < nsym; n++) begin
			s = coded[$urandom_range(0, coded.size() - 1)];
			for (int i = tab_len[s] - 1; i >= 0; i--)
				send_op(CMD_DECODE, 0, tab_bits[s][i], n == nsym - 1 && i == 0);
		end
	endtask

	task automatic random_phase();
		int k, syms[$], s;
		if ($urandom_range(0, 5) != 0) send_op(CMD_CLEAR);
		k = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 128) : $urandom_range(1, 12);
		for (int i = 0; i < k; i++) begin
			s = $urandom_range(0, ALPHA - 1);
			syms.push_back(s);
			repeat ($urandom_range(1, k > 20 ? 2 : 9)) send_op(CMD_COUNT, s);
		end
		send_op(CMD_BUILD);
		if (tree_ok) builds_ok++;
		repeat ($urandom_range(3, 15))
			send_op(CMD_ENCODE, $urandom_range(0, 3) == 0 ? $urandom_range(0, ALPHA - 1)
				: syms[$urandom_range(0, syms.size() - 1)]);
		decode_stream($urandom_range(1, 12));
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 10))
				send_op($urandom_range(0, 3) == 0 ? 3'($urandom_range(0, 7)) : CMD_DECODE,
					$urandom_range(0, ALPHA - 1), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0) send_op(CMD_COUNT, $urandom_range(0, ALPHA - 1));
		decode_stream($urandom_range(1, 6));
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			stall_left = 400;
		end
		if (stall_left != 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			if (!quiet && $urandom_range(0, 7) == 0)
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
					: $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("huffman_build_encode_decode_top_test: errors");
			$finish;
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			got++;
			if (rsp.symbol_valid) decoded++;
			if (pending.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = pending.pop_front();
				if (rsp.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp.status);
					errors++;
				end
				if (rsp.symbol_out !== e.symbol_out) begin
					$error("symbol_out exp %0d got %0d", e.symbol_out, rsp.symbol_out);
					errors++;
				end
				if (rsp.symbol_valid !== e.symbol_valid) begin
					$error("symbol_valid exp %0d got %0d", e.symbol_valid, rsp.symbol_valid);
					errors++;
				end
				if (rsp.code_bits !== e.code_bits) begin
					$error("code_bits exp %h got %h", e.code_bits, rsp.code_bits);
					errors++;
				end
				if (rsp.code_length !== e.code_length) begin
					$error("code_length exp %0d got %0d", e.code_length, rsp.code_length);
					errors++;
				end
				if (rsp.distinct_symbols !== e.distinct_symbols) begin
					$error("distinct_symbols exp %0d got %0d", e.distinct_symbols,
						rsp.distinct_symbols);
					errors++;
				end
			end
		end
	end

	initial begin
		dir_row_t tab[$];
		req_t r;
		rsp_t t;
		model_clear();
		tab = '{
			'{CMD_ENCODE, 5, 0, 0, 1, ST_NOT_BUILT, 0},
			'{CMD_DECODE, 0, 1, 1, 1, ST_NOT_BUILT, 0},
			'{CMD_BUILD, 0, 0, 0, 1, ST_FEW, 0},
			'{CMD_COUNT, 0, 0, 0, 1, ST_OK, 0},
			'{CMD_BUILD, 0, 0, 0, 1, ST_FEW, 1},
			'{CMD_COUNT, 127, 0, 0, 1, ST_OK, 1},
			'{CMD_COUNT, 127, 1, 1, 1, ST_OK, 1},
			'{CMD_SPARE_A, 127, 1, 1, 1, ST_OK, 1},
			'{CMD_SPARE_B, 0, 0, 0, 1, ST_OK, 1},
			'{CMD_SPARE_C, 85, 1, 0, 1, ST_OK, 1},
			'{CMD_BUILD, 0, 0, 0, 0, ST_OK, 0},
			'{CMD_ENCODE, 0, 0, 0, 0, ST_OK, 0},
			'{CMD_ENCODE, 127, 0, 0, 0, ST_OK, 0},
			'{CMD_ENCODE, 64, 0, 0, 1, ST_UNKNOWN, 2},
			'{CMD_DECODE, 0, 0, 0, 0, ST_OK, 0},
			'{CMD_DECODE, 0, 1, 1, 0, ST_OK, 0},
			'{CMD_COUNT, 64, 0, 0, 0, ST_OK, 0},
			'{CMD_COUNT, 64, 0, 0, 0, ST_OK, 0},
			'{CMD_BUILD, 0, 0, 0, 0, ST_OK, 0},
			'{CMD_DECODE, 0, 1, 1, 0, ST_OK, 0},
			'{CMD_DECODE, 0, 0, 1, 0, ST_OK, 0},
			'{CMD_DECODE, 0, 1, 0, 0, ST_OK, 0},
			'{CMD_DECODE, 0, 1, 1, 0, ST_OK, 0},
			'{CMD_CLEAR, 0, 0, 0, 1, ST_OK, 0},
			'{CMD_DECODE, 0, 0, 0, 1, ST_NOT_BUILT, 0}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (tab[i]) begin
			r = '{command: tab[i].cmd, symbol: tab[i].sym, bit_req: tab[i].b,
				last: tab[i].lst};
			t = '0;
			t.status = tab[i].st;
			t.distinct_symbols = tab[i].dcount;
			send(r, tab[i].fixed, t);
		end

		// counts run back to back
		quiet = 1;
		repeat (40) send_op(CMD_COUNT, 9);
		quiet = 0;
		send_op(CMD_COUNT, 120);
		send_op(CMD_COUNT, 33);
		send_op(CMD_BUILD);
		send_op(CMD_ENCODE, 9);
		send_op(CMD_ENCODE, 120);
		decode_stream(4);

		// long output hold-off while requests keep coming
		hold_req = 1;
		repeat (30) send_op(CMD_ENCODE, $urandom_range(0, ALPHA - 1));

		while (sent < RANDOM_ITEMS) begin
			quiet = $urandom_range(0, 4) == 0;
			random_phase();
		end
		quiet = 0;
		req_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("requests %0d, results %0d, good builds %0d, symbols decoded %0d",
			sent, got, builds_ok, decoded);
		if (errors == 0 && pending.size() == 0)
			$display("huffman_build_encode_decode_top_test: clean");
		else
			$display("huffman_build_encode_decode_top_test: errors");
		$finish;
	end

endmodule
